[src/bgfs_pkg.sv]
package bgfs_pkg;

    localparam int NUM_SCREENS = 2;

    localparam logic [1:0] SLOT_EMPTY  = 2'd2;
    localparam logic [1:0] MAX_PENDING = 2'd1;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_ACT    = 3;

    typedef enum logic [2:0] {
        REQ_SCAN_START  = 3'd0,
        REQ_BLANK_START = 3'd1,
        REQ_RENDER_DONE = 3'd2,
        REQ_RENDER_SKIP = 3'd3,
        REQ_XFER_DONE   = 3'd4
    } req_kind_t;

    typedef enum logic [1:0] {
        ACT_RENDER = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_FREE   = 2'd2
    } act_kind_t;

    typedef struct packed {
        logic [1:0] rend;
        logic [1:0] rdy;
        logic [1:0] xfr;
        logic       pref;
        logic       blank;
        logic       want;
    } scr_state_t;

    typedef struct packed {
        act_kind_t kind;
        logic      screen;
        logic      slot;
        logic      last;
    } action_t;

    typedef struct packed {
        scr_state_t st;
        logic       go;
        logic       slot;
    } render_res_t;

    function automatic logic slot_free(input scr_state_t st, input logic slot);
        logic [1:0] code;
        code = {1'b0, slot};
        return (code != st.rend) && (code != st.rdy) && (code != st.xfr);
    endfunction

    function automatic render_res_t render_try(input scr_state_t st);
        render_res_t r;
        logic [1:0]  pend;
        logic        pick;
        logic        ok;
        r.st   = st;
        r.go   = 1'b0;
        r.slot = 1'b0;
        pend   = 2'(st.rdy != SLOT_EMPTY) + 2'(st.xfr != SLOT_EMPTY);
        pick   = st.pref;
        ok     = slot_free(st, pick);
        if (!ok)
        begin
            pick = ~pick;
            ok   = slot_free(st, pick);
        end
        if (st.want && (st.rend == SLOT_EMPTY) && (pend <= MAX_PENDING) && ok)
        begin
            r.st.rend = {1'b0, pick};
            r.st.pref = ~pick;
            r.st.want = 1'b0;
            r.go      = 1'b1;
            r.slot    = pick;
        end
        return r;
    endfunction

endpackage

[src/blank_gated_frame_scheduler.sv]
// Frame scheduler for double-buffered panels on one shared write bus. Each accepted event
// (scan start, blank start, render done, render skipped, transfer done) is latched in an
// input register and resolved when the queue has room, which updates the per-screen buffer
// roles and pushes zero to three actions (buffer-free notice, write request, render
// request, in that order, the final one flagged by last_action) into an 8-entry action
// queue. The first action of an event passes the input register, action queue and output
// register before it appears. Events are taken one per cycle while the queue has room for
// three more actions; the action port delivers one action per cycle while act_stall is
// low, so events with several actions (at most 3) go no faster than the actions drain.
// Screens win the bus in fixed order, lowest index first, and only while blanking.
module blank_gated_frame_scheduler
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [2:0] req_type,
    input  logic       screen_id,
    input  logic       buffer_slot,
    output logic       act_valid,
    input  logic       act_stall,
    output logic [1:0] action_kind,
    output logic       target_screen,
    output logic       target_slot,
    output logic       last_action
);

    bgfs_pkg::scr_state_t scr_reg  [bgfs_pkg::NUM_SCREENS];
    bgfs_pkg::scr_state_t scr_next [bgfs_pkg::NUM_SCREENS];
    logic                 busy_reg;
    logic                 busy_next;

    logic       in_full_reg;
    logic       in_full_next;
    logic [2:0] type_reg;
    logic       sid_reg;
    logic       slot_reg;

    bgfs_pkg::action_t          fifo_mem [bgfs_pkg::FIFO_DEPTH];
    logic [bgfs_pkg::PTR_W-1:0] wr_ptr_reg;
    logic [bgfs_pkg::PTR_W-1:0] rd_ptr_reg;
    logic [bgfs_pkg::CNT_W-1:0] count_reg;
    logic [bgfs_pkg::CNT_W-1:0] count_next;

    logic       room;
    logic       load;
    logic       proc;
    logic       pop;
    logic       fetch;
    logic       type_ok;
    logic       scr_ok;
    logic [bgfs_pkg::NUM_SCREENS-1:0] sel;
    logic       do_note;
    logic       do_xfer;
    logic       do_rend;
    logic       xfer_found;
    logic       xfer_scr;
    logic       grant_slot;
    logic       rend_slot;
    logic       any_xfer;
    logic [1:0] wr_cnt;
    bgfs_pkg::action_t     ent [bgfs_pkg::MAX_ACT];
    bgfs_pkg::render_res_t rres;
    logic                  act_valid_reg;
    bgfs_pkg::action_t     act_reg;

    assign room = count_reg <= bgfs_pkg::CNT_W'(bgfs_pkg::FIFO_DEPTH - bgfs_pkg::MAX_ACT);
    assign proc = in_full_reg && room;
    assign req_stall = in_full_reg && !room;
    assign load = req_valid && !req_stall;
    assign act_valid = act_valid_reg;
    assign pop = act_valid_reg && !act_stall;
    assign fetch = (count_reg != '0) && (!act_valid_reg || pop);
    assign type_ok = type_reg <= bgfs_pkg::REQ_XFER_DONE;

    always_comb
    begin
        for (int s = 0; s < bgfs_pkg::NUM_SCREENS; s++)
        begin
            sel[s] = int'(sid_reg) == s;
        end
        scr_ok = |sel;
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (load)
        begin
            in_full_next = 1'b1;
        end
        else if (proc)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        scr_next   = scr_reg;
        busy_next  = busy_reg;
        do_note    = 1'b0;
        do_xfer    = 1'b0;
        do_rend    = 1'b0;
        xfer_found = 1'b0;
        xfer_scr   = 1'b0;
        grant_slot = 1'b0;
        rend_slot  = 1'b0;
        rres       = '0;
        if (proc && scr_ok && type_ok)
        begin
            for (int s = 0; s < bgfs_pkg::NUM_SCREENS; s++)
            begin
                if (sel[s])
                begin
                    unique case (type_reg)
                        bgfs_pkg::REQ_SCAN_START:
                        begin
                            scr_next[s].blank = 1'b0;
                            scr_next[s].want  = 1'b1;
                        end
                        bgfs_pkg::REQ_BLANK_START:
                        begin
                            scr_next[s].blank = 1'b1;
                        end
                        bgfs_pkg::REQ_RENDER_DONE:
                        begin
                            if (scr_next[s].rend == {1'b0, slot_reg})
                            begin
                                scr_next[s].rend = bgfs_pkg::SLOT_EMPTY;
                            end
                            scr_next[s].rdy = {1'b0, slot_reg};
                        end
                        bgfs_pkg::REQ_RENDER_SKIP:
                        begin
                            if (scr_next[s].rend == {1'b0, slot_reg})
                            begin
                                scr_next[s].rend = bgfs_pkg::SLOT_EMPTY;
                            end
                        end
                        bgfs_pkg::REQ_XFER_DONE:
                        begin
                            if (scr_next[s].xfr == {1'b0, slot_reg})
                            begin
                                scr_next[s].xfr = bgfs_pkg::SLOT_EMPTY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            if (type_reg == bgfs_pkg::REQ_XFER_DONE)
            begin
                busy_next = 1'b0;
                do_note   = 1'b1;
            end

            if ((type_reg == bgfs_pkg::REQ_BLANK_START) ||
                (type_reg == bgfs_pkg::REQ_RENDER_DONE) ||
                (type_reg == bgfs_pkg::REQ_XFER_DONE))
            begin
                if (!busy_next)
                begin
                    for (int s = 0; s < bgfs_pkg::NUM_SCREENS; s++)
                    begin
                        if (!xfer_found && (scr_next[s].rdy != bgfs_pkg::SLOT_EMPTY) &&
                            scr_next[s].blank)
                        begin
                            xfer_found       = 1'b1;
                            xfer_scr         = s[0];
                            grant_slot       = scr_next[s].rdy[0];
                            scr_next[s].xfr  = scr_next[s].rdy;
                            scr_next[s].rdy  = bgfs_pkg::SLOT_EMPTY;
                        end
                    end
                    busy_next = xfer_found;
                    do_xfer   = xfer_found;
                end
            end

            if (type_reg != bgfs_pkg::REQ_BLANK_START)
            begin
                for (int s = 0; s < bgfs_pkg::NUM_SCREENS; s++)
                begin
                    if (sel[s])
                    begin
                        rres        = bgfs_pkg::render_try(scr_next[s]);
                        scr_next[s] = rres.st;
                        do_rend     = rres.go;
                        rend_slot   = rres.slot;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < bgfs_pkg::MAX_ACT; k++)
        begin
            ent[k] = '0;
        end
        wr_cnt = 2'd0;
        if (do_note)
        begin
            ent[wr_cnt].kind   = bgfs_pkg::ACT_FREE;
            ent[wr_cnt].screen = sid_reg;
            ent[wr_cnt].slot   = slot_reg;
            wr_cnt             = wr_cnt + 2'd1;
        end
        if (do_xfer)
        begin
            ent[wr_cnt].kind   = bgfs_pkg::ACT_WRITE;
            ent[wr_cnt].screen = xfer_scr;
            ent[wr_cnt].slot   = grant_slot;
            wr_cnt             = wr_cnt + 2'd1;
        end
        if (do_rend)
        begin
            ent[wr_cnt].kind   = bgfs_pkg::ACT_RENDER;
            ent[wr_cnt].screen = sid_reg;
            ent[wr_cnt].slot   = rend_slot;
            wr_cnt             = wr_cnt + 2'd1;
        end
        if (wr_cnt != 2'd0)
        begin
            ent[wr_cnt - 2'd1].last = 1'b1;
        end
    end

    assign count_next = count_reg + bgfs_pkg::CNT_W'(wr_cnt) - bgfs_pkg::CNT_W'(fetch);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < bgfs_pkg::NUM_SCREENS; s++)
            begin
                scr_reg[s].rend  <= bgfs_pkg::SLOT_EMPTY;
                scr_reg[s].rdy   <= bgfs_pkg::SLOT_EMPTY;
                scr_reg[s].xfr   <= bgfs_pkg::SLOT_EMPTY;
                scr_reg[s].pref  <= 1'b0;
                scr_reg[s].blank <= 1'b0;
                scr_reg[s].want  <= 1'b0;
            end
            busy_reg      <= 1'b0;
            in_full_reg   <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            act_valid_reg <= 1'b0;
        end
        else
        begin
            scr_reg       <= scr_next;
            busy_reg      <= busy_next;
            in_full_reg   <= in_full_next;
            wr_ptr_reg    <= wr_ptr_reg + bgfs_pkg::PTR_W'(wr_cnt);
            rd_ptr_reg    <= rd_ptr_reg + bgfs_pkg::PTR_W'(fetch);
            count_reg     <= count_next;
            act_valid_reg <= fetch || (act_valid_reg && !pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            type_reg <= req_type;
            sid_reg  <= screen_id;
            slot_reg <= buffer_slot;
        end
        for (int k = 0; k < bgfs_pkg::MAX_ACT; k++)
        begin
            if (2'(k) < wr_cnt)
            begin
                fifo_mem[wr_ptr_reg + bgfs_pkg::PTR_W'(k)] <= ent[k];
            end
        end
        if (fetch)
        begin
            act_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    assign action_kind   = act_reg.kind;
    assign target_screen = act_reg.screen;
    assign target_slot   = act_reg.slot;
    assign last_action   = act_reg.last;

    always_comb
    begin
        any_xfer = 1'b0;
        for (int s = 0; s < bgfs_pkg::NUM_SCREENS; s++)
        begin
            any_xfer = any_xfer || (scr_reg[s].xfr != bgfs_pkg::SLOT_EMPTY);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bgfs_pkg::CNT_W'(bgfs_pkg::FIFO_DEPTH))
        else $error("action queue overflow");

    a_busy_has_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> any_xfer)
        else $error("bus busy with no transfer slot held");

    a_xfer_done_notice: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && scr_ok && (type_reg == bgfs_pkg::REQ_XFER_DONE)) |->
        (do_note && (ent[0].kind == bgfs_pkg::ACT_FREE)))
        else $error("transfer done without buffer free notice first");

endmodule

[sim/blank_gated_frame_scheduler_tb.sv]
module blank_gated_frame_scheduler_tb;

    typedef struct packed {
        bgfs_pkg::act_kind_t kind;
        logic                scr;
        logic                slot;
        logic                last;
    } frame_action_t;

    typedef struct {
        logic [2:0] kind;
        logic       scr;
        logic       slot;
        int         gap;
        bit         pause;
    } pending_item_t;

    logic       clk;
    logic       rst_n;
    logic       req_valid   = 1'b0;
    logic       req_stall;
    logic [2:0] req_type    = 3'd0;
    logic       screen_id   = 1'b0;
    logic       buffer_slot = 1'b0;
    logic       act_valid;
    logic       act_stall   = 1'b0;
    logic [1:0] action_kind;
    logic       target_screen;
    logic       target_slot;
    logic       last_action;

    logic [1:0] rend_slot   [bgfs_pkg::NUM_SCREENS];
    logic [1:0] queued_slot [bgfs_pkg::NUM_SCREENS];
    logic [1:0] bus_slot    [bgfs_pkg::NUM_SCREENS];
    logic       pref_slot   [bgfs_pkg::NUM_SCREENS];
    logic       blanking    [bgfs_pkg::NUM_SCREENS];
    logic       wanted      [bgfs_pkg::NUM_SCREENS];
    logic       bus_held;

    frame_action_t event_actions[$];
    frame_action_t expected_actions[$];
    pending_item_t pending_items[$];
    pending_item_t head_item;
    frame_action_t want_act;

    int gap_left;
    int stall_left;
    int mode_left;
    bit stall_calm;
    int errors = 0;

    blank_gated_frame_scheduler DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .screen_id     (screen_id),
        .buffer_slot   (buffer_slot),
        .act_valid     (act_valid),
        .act_stall     (act_stall),
        .action_kind   (action_kind),
        .target_screen (target_screen),
        .target_slot   (target_slot),
        .last_action   (last_action)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic slot_is_free(int s, logic sl);
        return ({1'b0, sl} != rend_slot[s]) && ({1'b0, sl} != queued_slot[s]) &&
               ({1'b0, sl} != bus_slot[s]);
    endfunction

    task automatic post_action(input bgfs_pkg::act_kind_t k, input int s, input logic sl);
        frame_action_t a;
        a.kind = k;
        a.scr  = s[0];
        a.slot = sl;
        a.last = 1'b0;
        event_actions.push_back(a);
    endtask

    task automatic start_render(input int s);
        int   pend;
        logic pick;
        if (!wanted[s] || rend_slot[s] != bgfs_pkg::SLOT_EMPTY)
            return;
        pend = int'(queued_slot[s] != bgfs_pkg::SLOT_EMPTY) +
               int'(bus_slot[s] != bgfs_pkg::SLOT_EMPTY);
        if (pend > int'(bgfs_pkg::MAX_PENDING))
            return;
        pick = pref_slot[s];
        if (!slot_is_free(s, pick))
        begin
            pick = ~pick;
            if (!slot_is_free(s, pick))
                return;
        end
        rend_slot[s] = {1'b0, pick};
        pref_slot[s] = ~pick;
        wanted[s]    = 1'b0;
        post_action(bgfs_pkg::ACT_RENDER, s, pick);
    endtask

    task automatic grant_bus();
        if (bus_held)
            return;
        for (int s = 0; s < bgfs_pkg::NUM_SCREENS; s++)
        begin
            if (queued_slot[s] != bgfs_pkg::SLOT_EMPTY && blanking[s])
            begin
                bus_held       = 1'b1;
                bus_slot[s]    = queued_slot[s];
                queued_slot[s] = bgfs_pkg::SLOT_EMPTY;
                post_action(bgfs_pkg::ACT_WRITE, s, bus_slot[s][0]);
                return;
            end
        end
    endtask

    task automatic schedule_event(input logic [2:0] kind, input logic scr, input logic sl);
        int            s;
        frame_action_t a;
        s = int'(scr);
        event_actions.delete();
        case (kind)
            bgfs_pkg::REQ_SCAN_START:
            begin
                blanking[s] = 1'b0;
                wanted[s]   = 1'b1;
                start_render(s);
            end
            bgfs_pkg::REQ_BLANK_START:
            begin
                blanking[s] = 1'b1;
                grant_bus();
            end
            bgfs_pkg::REQ_RENDER_DONE:
            begin
                if (rend_slot[s] == {1'b0, sl})
                    rend_slot[s] = bgfs_pkg::SLOT_EMPTY;
                queued_slot[s] = {1'b0, sl};
                grant_bus();
                start_render(s);
            end
            bgfs_pkg::REQ_RENDER_SKIP:
            begin
                if (rend_slot[s] == {1'b0, sl})
                    rend_slot[s] = bgfs_pkg::SLOT_EMPTY;
                start_render(s);
            end
            bgfs_pkg::REQ_XFER_DONE:
            begin
                if (bus_slot[s] == {1'b0, sl})
                    bus_slot[s] = bgfs_pkg::SLOT_EMPTY;
                bus_held = 1'b0;
                post_action(bgfs_pkg::ACT_FREE, s, sl);
                grant_bus();
                start_render(s);
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < event_actions.size(); i++)
        begin
            a      = event_actions[i];
            a.last = (i == event_actions.size() - 1);
            expected_actions.push_back(a);
        end
    endtask

    task automatic queue_item(input logic [2:0] k, input logic scr, input logic sl,
                              input int gap, input bit pause);
        pending_item_t p;
        p.kind  = k;
        p.scr   = scr;
        p.slot  = sl;
        p.gap   = gap;
        p.pause = pause;
        pending_items.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid   <= 1'b0;
            req_type    <= 3'd0;
            screen_id   <= 1'b0;
            buffer_slot <= 1'b0;
            gap_left    <= 0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
                schedule_event(req_type, screen_id, buffer_slot);
            if (gap_left != 0)
            begin
                req_valid <= 1'b0;
                gap_left  <= gap_left - 1;
            end
            else if (pending_items.size() == 0)
                req_valid <= 1'b0;
            else
            begin
                head_item = pending_items[0];
                if (head_item.pause)
                begin
                    req_valid <= 1'b0;
                    if (expected_actions.size() == 0)
                        head_item = pending_items.pop_front();
                end
                else
                begin
                    head_item   = pending_items.pop_front();
                    req_valid   <= 1'b1;
                    req_type    <= head_item.kind;
                    screen_id   <= head_item.scr;
                    buffer_slot <= head_item.slot;
                    gap_left    <= head_item.gap;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_stall  <= 1'b0;
            stall_left <= 0;
            mode_left  <= 0;
            stall_calm <= 1'b0;
        end
        else
        begin
            if (act_valid && !act_stall)
            begin
                if (expected_actions.size() == 0)
                begin
                    $display("%0t: expected no action, got kind=%0d screen=%0d slot=%0d last=%0d",
                             $time, action_kind, target_screen, target_slot, last_action);
                    errors++;
                end
                else
                begin
                    want_act = expected_actions.pop_front();
                    if (action_kind !== want_act.kind || target_screen !== want_act.scr ||
                        target_slot !== want_act.slot || last_action !== want_act.last)
                    begin
                        $display("%0t: expected kind=%0d screen=%0d slot=%0d last=%0d, %s",
                                 $time, want_act.kind, want_act.scr, want_act.slot,
                                 want_act.last, "got");
                        $display("%0t: actual   kind=%0d screen=%0d slot=%0d last=%0d",
                                 $time, action_kind, target_screen, target_slot,
                                 last_action);
                        errors++;
                    end
                end
            end
            if (mode_left == 0)
            begin
                mode_left  <= $urandom_range(50, 300);
                stall_calm <= ($urandom_range(0, 3) == 0);
            end
            else
                mode_left <= mode_left - 1;
            if (stall_left != 0)
            begin
                act_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                act_stall  <= 1'b0;
                stall_left <= pick_gap(stall_calm);
            end
        end
    end

    initial
    begin
        int         seg_left;
        bit         calm;
        int         phase       [bgfs_pkg::NUM_SCREENS];
        logic       gen_pref    [bgfs_pkg::NUM_SCREENS];
        logic       guess_rend  [bgfs_pkg::NUM_SCREENS];
        logic       guess_ready [bgfs_pkg::NUM_SCREENS];
        logic       guess_xfer  [bgfs_pkg::NUM_SCREENS];
        int         r;
        int         s;
        logic       sl;
        logic [2:0] k;

        for (int i = 0; i < bgfs_pkg::NUM_SCREENS; i++)
        begin
            rend_slot[i]   = bgfs_pkg::SLOT_EMPTY;
            queued_slot[i] = bgfs_pkg::SLOT_EMPTY;
            bus_slot[i]    = bgfs_pkg::SLOT_EMPTY;
            pref_slot[i]   = 1'b0;
            blanking[i]    = 1'b0;
            wanted[i]      = 1'b0;
            phase[i]       = 0;
            gen_pref[i]    = 1'b0;
            guess_rend[i]  = 1'b0;
            guess_ready[i] = 1'b0;
            guess_xfer[i]  = 1'b0;
        end
        bus_held = 1'b0;

        for (int u = bgfs_pkg::REQ_XFER_DONE + 1; u < 8; u++)
            queue_item(3'(u), u[0], u[1], pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_SCAN_START,  1'b0, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_RENDER_DONE, 1'b0, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_BLANK_START, 1'b0, 1'b1, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_SCAN_START,  1'b0, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_RENDER_DONE, 1'b0, 1'b1, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_SCAN_START,  1'b0, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_BLANK_START, 1'b0, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_XFER_DONE,   1'b0, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_RENDER_SKIP, 1'b0, 1'b1, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_RENDER_SKIP, 1'b0, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_XFER_DONE,   1'b1, 1'b1, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_XFER_DONE,   1'b1, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_SCAN_START,  1'b1, 1'b1, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_BLANK_START, 1'b1, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_RENDER_DONE, 1'b1, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_SCAN_START,  1'b0, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_RENDER_DONE, 1'b0, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_XFER_DONE,   1'b0, 1'b1, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_XFER_DONE,   1'b1, 1'b0, pick_gap(1'b0), 1'b0);
        queue_item(bgfs_pkg::REQ_SCAN_START,  1'b0, 1'b0, 0, 1'b1);

        seg_left = 0;
        calm     = 1'b0;
        for (int i = 0; i < 250; i++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 40);
                calm     = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            if (i == 125)
                queue_item(bgfs_pkg::REQ_SCAN_START, 1'b0, 1'b0, 0, 1'b1);
            s = $urandom_range(0, bgfs_pkg::NUM_SCREENS - 1);
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                k  = 3'($urandom_range(0, 7));
                sl = 1'($urandom_range(0, 1));
            end
            else
            begin
                case (phase[s])
                    0:
                    begin
                        k             = bgfs_pkg::REQ_SCAN_START;
                        sl            = 1'($urandom_range(0, 1));
                        guess_rend[s] = gen_pref[s];
                        gen_pref[s]   = ~gen_pref[s];
                    end
                    1:
                    begin
                        k  = (r < 85) ? bgfs_pkg::REQ_RENDER_DONE : bgfs_pkg::REQ_RENDER_SKIP;
                        sl = (r % 10 == 0) ? ~guess_rend[s] : guess_rend[s];
                        if (k == bgfs_pkg::REQ_RENDER_DONE)
                            guess_ready[s] = sl;
                    end
                    2:
                    begin
                        k             = bgfs_pkg::REQ_BLANK_START;
                        sl            = 1'($urandom_range(0, 1));
                        guess_xfer[s] = guess_ready[s];
                    end
                    default:
                    begin
                        k  = bgfs_pkg::REQ_XFER_DONE;
                        sl = (r % 13 == 0) ? ~guess_xfer[s] : guess_xfer[s];
                    end
                endcase
                if (r % 11 == 0)
                    phase[s] = $urandom_range(0, 3);
                else
                    phase[s] = (phase[s] + 1) % 4;
            end
            queue_item(k, s[0], sl, pick_gap(calm), 1'b0);
        end

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || req_valid || expected_actions.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
